### rtl/clc_pkg.sv
// Shared constants for the classical letter cipher core.
package clc_pkg;

   localparam int KEY_BYTES_DEF = 16;
   localparam int KEY_BYTES_MAX = 16;

   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 2;
   localparam int SHIFT_W = 5;
   localparam int LEN_W   = 5;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 64;
   localparam int HALF_KEY_BYTES = 8;

   // cipher modes
   localparam logic [MODE_W-1:0] MODE_CAESAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VIGENERE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_XOR      = 2'd2;

   // register indexes on the csr channel
   localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [IDX_W-1:0] REG_DIRECTION = 3'd1;
   localparam logic [IDX_W-1:0] REG_SHIFT     = 3'd2;
   localparam logic [IDX_W-1:0] REG_KEY_LEN   = 3'd3;
   localparam logic [IDX_W-1:0] REG_KEY_LOW   = 3'd4;
   localparam logic [IDX_W-1:0] REG_KEY_HIGH  = 3'd5;

   localparam logic [SHIFT_W-1:0] ALPHA_LEN   = 5'd26;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd3;
   localparam logic [BYTE_W-1:0]  CHAR_LA     = 8'h61;  // 'a'
   localparam logic [BYTE_W-1:0]  CHAR_LZ     = 8'h7a;  // 'z'
   localparam logic [BYTE_W-1:0]  CHAR_UA     = 8'h41;  // 'A'
   localparam logic [BYTE_W-1:0]  CHAR_UZ     = 8'h5a;  // 'Z'

   // alphabet index of a byte in either case, 0 for non-letters
   function automatic logic [SHIFT_W-1:0] alpha_index(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] d;
      d = '0;
      if (c >= CHAR_LA && c <= CHAR_LZ) begin
         d = c - CHAR_LA;
      end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
         d = c - CHAR_UA;
      end
      return d[SHIFT_W-1:0];
   endfunction

endpackage

### rtl/clc_if.sv
// Channel interfaces: text request, text response, register write.
interface clc_req_if import clc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              message_start;

   modport source (output valid, output in_byte, output message_start, input ready);
   modport sink   (input valid, input in_byte, input message_start, output ready);
endinterface

interface clc_rsp_if import clc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

interface clc_csr_if import clc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/classical_letter_cipher_core.sv
// Classical letter cipher: caesar, vigenere, repeating-key xor; one byte per cycle unless stalled.
// Pipeline: a request passes the input register, then the result register, to the response.
// Throughput: one byte per cycle unless the response channel stalls; key position is updated
//   in the same cycle the result register loads, so consecutive bytes chain without bubbles.
// Reset (synchronous, active high): pipeline empty, key position 0, mode caesar, encrypt,
//   shift 3, key length 1, key bytes zero. Register writes are accepted every cycle.
module classical_letter_cipher_core
   import clc_pkg::*;
#(
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   clc_req_if.sink       req_ch,
   clc_rsp_if.source     rsp_ch,
   clc_csr_if.sink       csr_ch
);

   localparam int POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEY_BYTES);

   // configuration registers
   logic [MODE_W-1:0]                  mode_ff;
   logic                               dir_ff;
   logic [SHIFT_W-1:0]                 shift_ff;
   logic [LEN_W-1:0]                   key_len_ff;
   logic [KEY_BYTES-1:0][BYTE_W-1:0]   key_ff;

   // pipeline
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_start_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [BYTE_W-1:0] rsp_byte_in;
   logic [POS_W-1:0]  key_pos_ff;
   logic [POS_W-1:0]  key_pos_in;

   logic s1_adv;
   logic req_fire;
   logic csr_fire;

   // datapath
   logic [LEN_W-1:0]   eff_len;
   logic [POS_W-1:0]   pos_base;
   logic [POS_W-1:0]   pos;
   logic [LEN_W-1:0]   pos_inc;
   logic               is_lower;
   logic               is_upper;
   logic               is_letter;
   logic [BYTE_W-1:0]  base;
   logic [SHIFT_W-1:0] letter_idx;
   logic [BYTE_W-1:0]  key_byte;
   logic [SHIFT_W-1:0] caesar_sh;
   logic [SHIFT_W-1:0] sh;
   logic [SHIFT_W-1:0] add_amt;
   logic [SHIFT_W:0]   sum;
   logic [SHIFT_W:0]   sum_wrap;
   logic [BYTE_W-1:0]  shifted;
   logic               advance;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;

   assign s1_adv       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CAESAR;
         dir_ff     <= 1'b0;
         shift_ff   <= SHIFT_RESET;
         key_len_ff <= LEN_W'(1);
         key_ff     <= '0;
      end else if (csr_fire) begin
         unique case (csr_ch.index)
            REG_MODE:      mode_ff    <= csr_ch.data[MODE_W-1:0];
            REG_DIRECTION: dir_ff     <= csr_ch.data[0];
            REG_SHIFT:     shift_ff   <= csr_ch.data[SHIFT_W-1:0];
            REG_KEY_LEN:   key_len_ff <= csr_ch.data[LEN_W-1:0];
            REG_KEY_LOW: begin
               for (int i = 0; i < HALF_KEY_BYTES; i++) begin
                  if (i < KEY_BYTES) begin
                     key_ff[i] <= csr_ch.data[i*BYTE_W +: BYTE_W];
                  end
               end
            end
            REG_KEY_HIGH: begin
               for (int i = 0; i < HALF_KEY_BYTES; i++) begin
                  if (i + HALF_KEY_BYTES < KEY_BYTES) begin
                     key_ff[i + HALF_KEY_BYTES] <= csr_ch.data[i*BYTE_W +: BYTE_W];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // effective key length: 0 counts as 1, saturate at the key size
   always_comb begin
      priority if (key_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (key_len_ff > LEN_MAX) begin
         eff_len = LEN_MAX;
      end else begin
         eff_len = key_len_ff;
      end
   end

   always_comb begin
      pos_base   = s1_start_ff ? '0 : key_pos_ff;
      pos        = (LEN_W'(pos_base) < eff_len) ? pos_base : '0;
      pos_inc    = LEN_W'(pos) + LEN_W'(1);
      key_byte   = key_ff[pos];

      is_lower   = (s1_byte_ff >= CHAR_LA) && (s1_byte_ff <= CHAR_LZ);
      is_upper   = (s1_byte_ff >= CHAR_UA) && (s1_byte_ff <= CHAR_UZ);
      is_letter  = is_lower || is_upper;
      base       = is_lower ? CHAR_LA : CHAR_UA;
      letter_idx = alpha_index(s1_byte_ff);

      caesar_sh  = (shift_ff >= ALPHA_LEN) ? (shift_ff - ALPHA_LEN) : shift_ff;
      sh         = (mode_ff == MODE_VIGENERE) ? alpha_index(key_byte) : caesar_sh;
      // decrypt adds 26 - shift so one wrap step covers both directions
      add_amt    = dir_ff ? (ALPHA_LEN - sh) : sh;
      sum        = {1'b0, letter_idx} + {1'b0, add_amt};
      sum_wrap   = (sum >= {1'b0, ALPHA_LEN}) ? (sum - {1'b0, ALPHA_LEN}) : sum;
      shifted    = base + BYTE_W'(sum_wrap);

      rsp_byte_in = s1_byte_ff;
      advance     = 1'b0;
      unique case (mode_ff)
         MODE_CAESAR: begin
            if (is_letter) begin
               rsp_byte_in = shifted;
            end
         end
         MODE_VIGENERE: begin
            if (is_letter) begin
               rsp_byte_in = shifted;
               advance     = 1'b1;
            end
         end
         MODE_XOR: begin
            rsp_byte_in = s1_byte_ff ^ key_byte;
            advance     = 1'b1;
         end
         default: ;
      endcase

      if (advance) begin
         key_pos_in = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
      end else begin
         key_pos_in = pos_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_pos_ff   <= '0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            key_pos_ff   <= key_pos_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_ch.in_byte;
         s1_start_ff <= req_ch.message_start;
      end
      if (s1_adv) begin
         rsp_byte_ff <= rsp_byte_in;
      end
   end

   // a held stage-one transaction keeps its byte
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("stage one transaction lost or changed while stalled");

   // letter modes pass non-letters through untouched
   a_nonletter_pass: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (mode_ff == MODE_CAESAR || mode_ff == MODE_VIGENERE) && !is_letter
      |=> rsp_byte_ff == $past(s1_byte_ff))
      else $error("non-letter altered in letter mode");

   // caesar mode never moves the key position except on message start
   a_caesar_pos: assert property (@(posedge clock) disable iff (reset)
      s1_adv && mode_ff == MODE_CAESAR && !s1_start_ff |=> $stable(key_pos_ff))
      else $error("key position moved in caesar mode");

   // key position stays inside the key
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> LEN_W'(key_pos_ff) < LEN_MAX)
      else $error("key position out of range");

endmodule

### verif/classical_letter_cipher_core_tb.sv
// Self-checking testbench for the classical letter cipher core: directed and random text.
module classical_letter_cipher_core_tb;
   import clc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int RAND_PHASES     = 16;
   localparam int PHASE_ITEMS     = 125;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              message_start;
   } text_item_type;

   logic clock;
   logic reset;

   clc_req_if req_ch ();
   clc_rsp_if rsp_ch ();
   clc_csr_if csr_ch ();

   classical_letter_cipher_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow copy of the block's registers and key position
   logic [MODE_W-1:0]  cfg_mode;
   logic               cfg_dir;
   logic [SHIFT_W-1:0] cfg_shift;
   logic [LEN_W-1:0]   cfg_key_len;
   logic [DATA_W-1:0]  cfg_key_low;
   logic [DATA_W-1:0]  cfg_key_high;
   logic [3:0]         key_pos;

   text_item_type     text_queue[$];
   logic [BYTE_W-1:0] cipher_expect[$];

   int n_req_loaded;
   int n_req_taken;
   int n_fail;
   int quiet_cycles;
   int src_idle_pct;
   int sink_stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] rotate_letter(input logic [BYTE_W-1:0] c,
                                                       input int sh);
      int base;
      int idx;
      base = (c >= "a" && c <= "z") ? "a" : "A";
      idx  = c - base;
      sh   = sh % 26;
      if (cfg_dir)
         idx = (idx + 26 - sh) % 26;
      else
         idx = (idx + sh) % 26;
      return BYTE_W'(base + idx);
   endfunction

   // expected output byte; advances the shadow key position
   function automatic logic [BYTE_W-1:0] cipher_predict(input logic [BYTE_W-1:0] c,
                                                        input logic start);
      logic [2*DATA_W-1:0] key_bytes;
      logic [BYTE_W-1:0]   kb;
      logic [BYTE_W-1:0]   r;
      bit                  letter;
      bit                  adv;
      int                  len;
      int                  pos;
      int                  sh;
      key_bytes = {cfg_key_high, cfg_key_low};
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      adv = 1'b0;
      r = c;
      len = cfg_key_len;
      if (len < 1)
         len = 1;
      if (len > KEY_BYTES_MAX)
         len = KEY_BYTES_MAX;
      if (start)
         key_pos = '0;
      pos = (key_pos < len) ? key_pos : 0;   // stale position falls back to 0
      kb = key_bytes[8*pos +: 8];
      case (cfg_mode)
         MODE_CAESAR: begin
            if (letter)
               r = rotate_letter(c, cfg_shift);
         end
         MODE_VIGENERE: begin
            if (letter) begin
               sh = 0;
               if (kb >= "a" && kb <= "z")
                  sh = kb - "a";
               else if (kb >= "A" && kb <= "Z")
                  sh = kb - "A";
               r = rotate_letter(c, sh);
               adv = 1'b1;
            end
         end
         MODE_XOR: begin
            r = c ^ kb;
            adv = 1'b1;
         end
         default: r = c;
      endcase
      if (adv) begin
         pos = pos + 1;
         if (pos >= len)
            pos = 0;
         key_pos = pos[3:0];
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] rand_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return BYTE_W'($urandom_range("a", "z"));
      if (r < 70)
         return BYTE_W'($urandom_range("A", "Z"));
      if (r < 85)
         return BYTE_W'($urandom_range(8'h20, 8'h7e));
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [DATA_W-1:0] rand_key_word();
      logic [DATA_W-1:0] w;
      int r;
      for (int i = 0; i < HALF_KEY_BYTES; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4)
            w[8*i +: 8] = BYTE_W'($urandom_range("a", "z"));
         else if (r < 8)
            w[8*i +: 8] = BYTE_W'($urandom_range("A", "Z"));
         else
            w[8*i +: 8] = BYTE_W'($urandom_range(0, 255));
      end
      return w;
   endfunction

   task automatic push_text(input logic [BYTE_W-1:0] b, input logic s);
      text_item_type t;
      t.in_byte = b;
      t.message_start = s;
      text_queue.push_back(t);
   endtask

   // whole messages, mostly opened by a start flag; a few stray flags as noise
   task automatic push_messages(input int n);
      int left;
      int mlen;
      logic s;
      left = n;
      while (left > 0) begin
         mlen = $urandom_range(1, 40);
         if (mlen > left)
            mlen = left;
         for (int i = 0; i < mlen; i++) begin
            s = (i == 0) && ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 99) < 3)
               s = 1'b1;
            push_text(rand_text_byte(), s);
         end
         left -= mlen;
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (!(text_queue.size() == 0 && n_req_taken == n_req_loaded &&
               cipher_expect.size() == 0))
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = val;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      case (idx)
         REG_MODE:      cfg_mode     = val[MODE_W-1:0];
         REG_DIRECTION: cfg_dir      = val[0];
         REG_SHIFT:     cfg_shift    = val[SHIFT_W-1:0];
         REG_KEY_LEN:   cfg_key_len  = val[LEN_W-1:0];
         REG_KEY_LOW:   cfg_key_low  = val;
         REG_KEY_HIGH:  cfg_key_high = val;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic write_all(input logic [MODE_W-1:0] mode, input logic dir,
                            input logic [SHIFT_W-1:0] shift, input logic [LEN_W-1:0] klen,
                            input logic [DATA_W-1:0] klo, input logic [DATA_W-1:0] khi);
      write_reg(REG_MODE, DATA_W'(mode));
      write_reg(REG_DIRECTION, DATA_W'(dir));
      write_reg(REG_SHIFT, DATA_W'(shift));
      write_reg(REG_KEY_LEN, DATA_W'(klen));
      write_reg(REG_KEY_LOW, klo);
      write_reg(REG_KEY_HIGH, khi);
   endtask

   // request driver
   always @(negedge clock) begin : drive_text
      text_item_type nxt;
      if (!req_ch.valid || n_req_taken == n_req_loaded) begin
         if (text_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
            nxt = text_queue.pop_front();
            req_ch.valid         <= 1'b1;
            req_ch.in_byte       <= nxt.in_byte;
            req_ch.message_start <= nxt.message_start;
            n_req_loaded         <= n_req_loaded + 1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   // monitor: predict on request transactions, check response transactions
   always @(posedge clock) begin : watch_channels
      logic [BYTE_W-1:0] want;
      bit                moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            cipher_expect.push_back(cipher_predict(req_ch.in_byte, req_ch.message_start));
            n_req_taken = n_req_taken + 1;
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (cipher_expect.size() == 0) begin
               $error("out_byte: no expected result, actual %02h", rsp_ch.out_byte);
               n_fail++;
            end else begin
               want = cipher_expect.pop_front();
               if (rsp_ch.out_byte !== want) begin
                  $error("out_byte: expected %02h, actual %02h", want, rsp_ch.out_byte);
                  n_fail++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            moved = 1'b1;
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [MODE_W-1:0]  mode;
      logic [SHIFT_W-1:0] shift;
      logic [LEN_W-1:0]   klen;
      logic [DATA_W-1:0]  klo;
      logic [DATA_W-1:0]  khi;
      int                 r;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.in_byte = '0;
      req_ch.message_start = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      n_req_loaded = 0;
      n_req_taken = 0;
      n_fail = 0;
      quiet_cycles = 0;
      src_idle_pct = 0;
      sink_stall_pct = 0;
      cfg_mode = MODE_CAESAR;
      cfg_dir = 1'b0;
      cfg_shift = SHIFT_RESET;
      cfg_key_len = LEN_W'(1);
      cfg_key_low = '0;
      cfg_key_high = '0;
      key_pos = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: caesar shift 3, letter bounds and three of their neighbors
      @(posedge clock);
      push_text("a", 1'b1);
      push_text("z", 1'b0);
      push_text("A", 1'b0);
      push_text("Z", 1'b0);
      push_text(8'h00, 1'b0);
      push_text(8'hff, 1'b0);
      push_text("@", 1'b0);
      push_text("[", 1'b0);
      push_text("{", 1'b0);
      wait_idle();

      // caesar decrypt, shift above 25 wraps
      write_all(MODE_CAESAR, 1'b1, 5'd31, 5'd1, '0, '0);
      @(posedge clock);
      push_text("a", 1'b0);
      push_text("Z", 1'b0);
      wait_idle();

      // vigenere, zero key length acts as one
      write_all(MODE_VIGENERE, 1'b0, 5'd0, 5'd0, 64'h2161_7A5A_4D21_6B41,
                64'h7857_7730_7252_7151);
      @(posedge clock);
      push_text("x", 1'b1);
      push_text(" ", 1'b0);
      push_text("y", 1'b0);
      wait_idle();

      // key length saturates, mixed-case and non-letter key bytes
      write_reg(REG_KEY_LEN, DATA_W'(5'd31));
      @(posedge clock);
      push_text("q", 1'b1);
      push_text("R", 1'b0);
      push_text("s", 1'b0);
      push_text("T", 1'b0);
      wait_idle();

      // shorter key leaves the position past its end
      write_reg(REG_KEY_LEN, DATA_W'(5'd2));
      @(posedge clock);
      push_text("k", 1'b0);
      push_text("l", 1'b0);
      wait_idle();

      write_reg(REG_MODE, DATA_W'(MODE_UNUSED));
      @(posedge clock);
      push_text("a", 1'b0);
      push_text(8'hff, 1'b1);
      wait_idle();

      // xor with an all-zero low key
      write_all(MODE_XOR, 1'b1, 5'd25, 5'd16, '0, '1);
      @(posedge clock);
      push_text("A", 1'b1);
      push_text(8'h80, 1'b0);
      wait_idle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            mode = MODE_UNUSED;
         else if (r < 4)
            mode = MODE_CAESAR;
         else if (r < 7)
            mode = MODE_VIGENERE;
         else
            mode = MODE_XOR;
         shift = (ph == 4) ? 5'd0 : (ph == 5) ? 5'd25 : SHIFT_W'($urandom_range(0, 31));
         if (ph == 0)
            klen = 5'd16;
         else if (ph == 1)
            klen = 5'd1;
         else if ($urandom_range(0, 9) == 0)
            klen = LEN_W'($urandom_range(0, 31));
         else
            klen = LEN_W'($urandom_range(1, 16));
         klo = (ph == 2) ? '1 : (ph == 3) ? '0 : rand_key_word();
         khi = (ph == 2) ? '1 : (ph == 3) ? '0 : rand_key_word();
         write_all(mode, 1'($urandom_range(0, 1)), shift, klen, klo, khi);

         @(posedge clock);
         case (ph % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
            default: begin src_idle_pct = 37; sink_stall_pct = 37; end
         endcase
         push_messages(PHASE_ITEMS / 2);
         // sender holds off until the pipe has drained
         wait_idle();
         push_messages(PHASE_ITEMS - PHASE_ITEMS / 2);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (cipher_expect.size() != 0) begin
         $error("out_byte: %0d expected results never arrived", cipher_expect.size());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
